// File: hw/rtl/psgm_pkg.sv
// psgm_pkg: shared widths, codes and transfer structs of the sequence gap monitor
// used by psgm_front, psgm_back and the top level; depends on nothing
package psgm_pkg;

  localparam int CHANNELS_DEF = 64;
  localparam int MAX_PKT_DEF  = 16384;

  localparam int CH_W   = 6;
  localparam int BYTE_W = 8;
  localparam int SEQ_W  = 32;
  localparam int STAT_W = 3;
  localparam int PB_W   = 15;
  localparam int CNT_W  = 32;
  localparam int TOTB_W = 48;
  localparam int MASK_W = 64;
  localparam int ACC_W  = 35;
  localparam int IDX_W  = 4;

  localparam logic [ACC_W-1:0] TID_RESET_MSG = ACC_W'(120);
  localparam logic [ACC_W-1:0] TID_SEQ_RESET = ACC_W'(49);
  localparam logic [IDX_W-1:0] PLAIN_BYTES   = IDX_W'(4);
  localparam logic [IDX_W-1:0] FIELD_LIMIT   = IDX_W'(5);
  localparam logic [IDX_W-1:0] STIME_LIMIT   = IDX_W'(10);

  localparam logic [STAT_W-1:0] ST_NONE         = 3'd0;
  localparam logic [STAT_W-1:0] ST_FIRST        = 3'd1;
  localparam logic [STAT_W-1:0] ST_IN_ORDER     = 3'd2;
  localparam logic [STAT_W-1:0] ST_GAP          = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUT_OF_ORDER = 3'd4;
  localparam logic [STAT_W-1:0] ST_SEQ_RESET    = 3'd5;
  localparam logic [STAT_W-1:0] ST_RESET_MSG    = 3'd6;

  typedef enum logic [1:0] {
    KIND_ORDINARY,
    KIND_RESET_MSG,
    KIND_SEQ_RESET
  } kind_t;

  // one finished packet, front to back
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [SEQ_W-1:0]  seq;
    kind_t             kind;
    logic              ok;
    logic [PB_W-1:0]   len;
    logic [TOTB_W-1:0] bytes;
  } desc_t;

  // per-channel state entry
  typedef struct packed {
    logic [SEQ_W-1:0] last_seq;
    logic [CNT_W-1:0] gaps;
    logic [CNT_W-1:0] ord;
  } entry_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [SEQ_W-1:0]  seq;
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  diff;
    logic [PB_W-1:0]   pkt_bytes;
    logic [CNT_W-1:0]  ch_gaps;
    logic [CNT_W-1:0]  ch_ord;
    logic [CNT_W-1:0]  tot_gaps;
    logic [CNT_W-1:0]  tot_ord;
    logic [CNT_W-1:0]  pkt_total;
    logic [TOTB_W-1:0] byte_total;
  } res_t;

endpackage

// File: hw/rtl/psgm_ram.sv
// psgm_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module psgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/psgm_fifo.sv
// psgm_fifo: small register queue, used between front and back and on the result side
// depends on nothing
module psgm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/psgm_front.sv
// psgm_front: byte parser, one byte per cycle while byte_take is high, emits one descriptor per packet
// depends on psgm_pkg
module psgm_front #(
  parameter int MAX_PACKET_BYTES = psgm_pkg::MAX_PKT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr,
  input  logic [psgm_pkg::MASK_W-1:0] cfg_mask,
  input  logic                        byte_take,
  input  logic [psgm_pkg::CH_W-1:0]   byte_ch,
  input  logic [psgm_pkg::BYTE_W-1:0] byte_data,
  input  logic                        byte_last,
  output logic                        desc_push,
  output psgm_pkg::desc_t             desc
);
  import psgm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

  typedef enum logic [2:0] {
    PH_PLAIN, PH_PMAP, PH_TID, PH_SEQ, PH_STIME, PH_NEWSEQ, PH_DONE, PH_START
  } phase_t;

  logic [MASK_W-1:0] mask_r;
  phase_t            phase_r, ph_cur, ph_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_sh;
  kind_t             kind_r, kind_nxt;
  logic [SEQ_W-1:0]  cap_r, cap_nxt;
  logic              mal_r, mal_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TOTB_W-1:0] bytes_r, bytes_nxt;
  logic [IDX_W-1:0]  limit;

  always_comb begin
    ph_cur   = phase_r;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    kind_nxt = kind_r;
    cap_nxt  = cap_r;
    mal_nxt  = mal_r;
    len_nxt  = len_r;
    if (phase_r == PH_START) begin
      ph_cur   = mask_r[byte_ch] ? PH_PMAP : PH_PLAIN;
      idx_nxt  = '0;
      acc_nxt  = '0;
      kind_nxt = KIND_ORDINARY;
      cap_nxt  = '0;
      mal_nxt  = 1'b0;
      len_nxt  = '0;
    end
    if (len_nxt < LEN_W'(MAX_PACKET_BYTES)) begin
      len_nxt = len_nxt + 1'b1;
    end
    ph_nxt  = ph_cur;
    acc_sh  = {acc_nxt[ACC_W-8:0], byte_data[6:0]};
    idx_inc = idx_nxt + 1'b1;
    limit   = (ph_cur == PH_STIME) ? STIME_LIMIT : FIELD_LIMIT;
    case (ph_cur)
      PH_PLAIN: begin
        if (idx_nxt < PLAIN_BYTES) begin
          cap_nxt = {cap_nxt[SEQ_W-9:0], byte_data};
          idx_nxt = idx_inc;
          if (idx_inc == PLAIN_BYTES) begin
            ph_nxt = PH_DONE;
          end
        end
      end
      PH_PMAP: begin
        if (byte_data[7]) begin
          ph_nxt  = PH_TID;
          idx_nxt = '0;
          acc_nxt = '0;
        end
      end
      PH_TID, PH_SEQ, PH_STIME, PH_NEWSEQ: begin
        acc_nxt = acc_sh;
        idx_nxt = idx_inc;
        if (byte_data[7]) begin
          acc_nxt = '0;
          idx_nxt = '0;
          case (ph_cur)
            PH_TID: begin
              if (acc_sh == TID_RESET_MSG) begin
                kind_nxt = KIND_RESET_MSG;
                ph_nxt   = PH_DONE;
              end else begin
                kind_nxt = (acc_sh == TID_SEQ_RESET) ? KIND_SEQ_RESET : KIND_ORDINARY;
                ph_nxt   = PH_SEQ;
              end
            end
            PH_SEQ: begin
              cap_nxt = acc_sh[SEQ_W-1:0];
              ph_nxt  = (kind_nxt == KIND_SEQ_RESET) ? PH_STIME : PH_DONE;
            end
            PH_STIME: begin
              ph_nxt = PH_NEWSEQ;
            end
            default: begin
              cap_nxt = acc_sh[SEQ_W-1:0];
              ph_nxt  = PH_DONE;
            end
          endcase
        end else if (idx_inc >= limit) begin
          mal_nxt = 1'b1;
          ph_nxt  = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign bytes_nxt = bytes_r + 1'b1;
  assign desc_push = byte_take && byte_last;

  always_comb begin
    desc.ch    = byte_ch;
    desc.seq   = cap_nxt;
    desc.kind  = kind_nxt;
    desc.ok    = (ph_nxt == PH_DONE) && !mal_nxt;
    desc.len   = PB_W'(len_nxt);
    desc.bytes = bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      phase_r <= PH_START;
      bytes_r <= '0;
    end else begin
      if (cfg_wr) begin
        mask_r <= cfg_mask;
      end
      if (byte_take) begin
        bytes_r <= bytes_nxt;
        phase_r <= byte_last ? PH_START : ph_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      idx_r  <= idx_nxt;
      acc_r  <= acc_nxt;
      kind_r <= kind_nxt;
      cap_r  <= cap_nxt;
      mal_r  <= mal_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

// File: hw/rtl/psgm_back.sv
// psgm_back: per-channel sequence check and counters, two stages around the state RAM
// depends on psgm_pkg and psgm_ram
module psgm_back #(
  parameter int CHANNELS = psgm_pkg::CHANNELS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            desc_empty,
  input  psgm_pkg::desc_t desc,
  output logic            desc_pop,
  input  logic            res_full,
  output logic            res_push,
  output psgm_pkg::res_t  res
);
  import psgm_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] vld_r;
  logic                b_valid_r, b_done;
  desc_t               b_desc_r;
  logic                b_inr_r, b_vld_r, b_fwd_r;
  entry_t              b_fwd_data_r;
  logic                a_inr;
  logic [AW-1:0]       a_addr, b_addr;
  logic                wr_en, wr_req;
  entry_t              wr_data, ram_rd, ent;
  logic [SEQ_W-1:0]    prev, diff_full;
  logic [CNT_W-1:0]    gaps, ord;
  logic                gap_inc, ord_inc;
  logic [STAT_W-1:0]   status;
  logic [SEQ_W-1:0]    seq_out, diff_out;
  logic [CNT_W-1:0]    tot_gaps_r, tot_gaps_nxt;
  logic [CNT_W-1:0]    tot_ord_r, tot_ord_nxt;
  logic [CNT_W-1:0]    pkt_total_r, pkt_total_nxt;

  assign a_inr    = (32'(desc.ch) < 32'(CHANNELS));
  assign a_addr   = desc.ch[AW-1:0];
  assign b_addr   = b_desc_r.ch[AW-1:0];
  assign b_done   = b_valid_r && !res_full;
  assign desc_pop = !desc_empty && (!b_valid_r || b_done);
  assign res_push = b_done;
  assign wr_en    = b_done && wr_req;

  psgm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_addr),
    .wr_data (wr_data),
    .rd_en   (desc_pop),
    .rd_addr (a_addr),
    .rd_data (ram_rd)
  );

  // bypass a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      b_desc_r     <= desc;
      b_inr_r      <= a_inr;
      b_vld_r      <= a_inr && vld_r[a_addr];
      b_fwd_r      <= a_inr && wr_en && (b_addr == a_addr);
      b_fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    ent       = b_fwd_r ? b_fwd_data_r : (b_vld_r ? ram_rd : '0);
    prev      = ent.last_seq;
    diff_full = b_desc_r.seq - prev;
    gaps      = ent.gaps;
    ord       = ent.ord;
    status    = ST_NONE;
    seq_out   = '0;
    diff_out  = '0;
    gap_inc   = 1'b0;
    ord_inc   = 1'b0;
    wr_req    = 1'b0;
    if (b_inr_r && b_desc_r.ok) begin
      if (b_desc_r.kind == KIND_RESET_MSG) begin
        status  = ST_RESET_MSG;
        seq_out = prev;
      end else if (b_desc_r.seq != '0) begin
        wr_req  = 1'b1;
        seq_out = b_desc_r.seq;
        if (b_desc_r.kind == KIND_SEQ_RESET) begin
          status = ST_SEQ_RESET;
        end else if (prev == '0) begin
          status = ST_FIRST;
        end else begin
          diff_out = diff_full;
          if (diff_full[SEQ_W-1]) begin
            status  = ST_OUT_OF_ORDER;
            ord     = ord + 1'b1;
            ord_inc = 1'b1;
          end else if (diff_full > SEQ_W'(1)) begin
            status  = ST_GAP;
            gaps    = gaps + 1'b1;
            gap_inc = 1'b1;
          end else begin
            status = ST_IN_ORDER;
          end
        end
      end
    end
    wr_data.last_seq = b_desc_r.seq;
    wr_data.gaps     = gaps;
    wr_data.ord      = ord;
  end

  assign tot_gaps_nxt  = tot_gaps_r + CNT_W'(gap_inc);
  assign tot_ord_nxt   = tot_ord_r + CNT_W'(ord_inc);
  assign pkt_total_nxt = pkt_total_r + 1'b1;

  always_comb begin
    res.ch         = b_desc_r.ch;
    res.seq        = seq_out;
    res.status     = status;
    res.diff       = diff_out;
    res.pkt_bytes  = b_desc_r.len;
    res.ch_gaps    = b_inr_r ? gaps : '0;
    res.ch_ord     = b_inr_r ? ord : '0;
    res.tot_gaps   = tot_gaps_nxt;
    res.tot_ord    = tot_ord_nxt;
    res.pkt_total  = pkt_total_nxt;
    res.byte_total = b_desc_r.bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      vld_r       <= '0;
      tot_gaps_r  <= '0;
      tot_ord_r   <= '0;
      pkt_total_r <= '0;
    end else begin
      if (desc_pop) begin
        b_valid_r <= 1'b1;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[b_addr] <= 1'b1;
      end
      if (b_done) begin
        tot_gaps_r  <= tot_gaps_nxt;
        tot_ord_r   <= tot_ord_nxt;
        pkt_total_r <= pkt_total_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/packet_sequence_gap_monitor.sv
// packet_sequence_gap_monitor: top level, front parser, descriptor queue, back checker,
// result queue; depends on psgm_pkg, psgm_fifo, psgm_front, psgm_back
//
// Usage:
//   Input is a queue port: one packet byte (channel, byte, last mark) per transfer,
//   taken when push is high and full is low. Results are a queue port too: the
//   oldest result sits on the out_ ports while empty is low and leaves on pop.
//   cfg_stop_bit_format_mask is written on a cfg_valid/cfg_ready transfer; the user
//   must write it only while idle (not enforced here). cfg_ready is always high.
//   Throughput: one byte per cycle while full is low; a packet may end on every such
//   cycle. The per-channel state RAM is read on a descriptor pop and written on its
//   result push, with a bypass for back-to-back packets on one channel, so the back
//   end keeps that rate. A packet's descriptor is pushed with its last byte and passes
//   the descriptor queue, the back stage and the result queue to the out_ ports.
//   Reset clears the parser, the totals and the per-channel valid bits; there is no
//   clearing pass, and bytes are taken right after reset.
//   When the receiver stops popping, the result queue fills, the back end holds,
//   the 4-entry descriptor queue fills and then full rises on the input side.
module packet_sequence_gap_monitor #(
  parameter int CHANNELS         = psgm_pkg::CHANNELS_DEF,
  parameter int MAX_PACKET_BYTES = psgm_pkg::MAX_PKT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psgm_pkg::MASK_W-1:0]       cfg_stop_bit_format_mask,
  input  logic                              push,
  output logic                              full,
  input  logic [psgm_pkg::CH_W-1:0]         in_channel,
  input  logic [psgm_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                              in_last_byte,
  output logic                              empty,
  input  logic                              pop,
  output logic [psgm_pkg::CH_W-1:0]         out_channel,
  output logic [psgm_pkg::SEQ_W-1:0]        out_sequence_number,
  output logic [psgm_pkg::STAT_W-1:0]       out_status,
  output logic signed [psgm_pkg::SEQ_W-1:0] out_sequence_diff,
  output logic [psgm_pkg::PB_W-1:0]         out_packet_bytes,
  output logic [psgm_pkg::CNT_W-1:0]        out_channel_gap_count,
  output logic [psgm_pkg::CNT_W-1:0]        out_channel_order_errors,
  output logic [psgm_pkg::CNT_W-1:0]        out_total_gap_count,
  output logic [psgm_pkg::CNT_W-1:0]        out_total_order_errors,
  output logic [psgm_pkg::CNT_W-1:0]        out_total_packets,
  output logic [psgm_pkg::TOTB_W-1:0]       out_total_byte_count
);
  import psgm_pkg::*;

  localparam int DESC_DEPTH = 4;
  localparam int RES_DEPTH  = 2;

  logic  byte_take;
  logic  desc_push, desc_full, desc_pop, desc_empty;
  desc_t desc_in, desc_out;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  assign cfg_ready = 1'b1;
  assign full      = desc_full;
  assign byte_take = push && !desc_full;

  psgm_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_mask  (cfg_stop_bit_format_mask),
    .byte_take (byte_take),
    .byte_ch   (in_channel),
    .byte_data (in_data_byte),
    .byte_last (in_last_byte),
    .desc_push (desc_push),
    .desc      (desc_in)
  );

  psgm_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_push),
    .wr_data (desc_in),
    .full    (desc_full),
    .pop     (desc_pop),
    .rd_data (desc_out),
    .empty   (desc_empty)
  );

  psgm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_empty (desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  psgm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_channel              = res_out.ch;
  assign out_sequence_number      = res_out.seq;
  assign out_status               = res_out.status;
  assign out_sequence_diff        = $signed(res_out.diff);
  assign out_packet_bytes         = res_out.pkt_bytes;
  assign out_channel_gap_count    = res_out.ch_gaps;
  assign out_channel_order_errors = res_out.ch_ord;
  assign out_total_gap_count      = res_out.tot_gaps;
  assign out_total_order_errors   = res_out.tot_ord;
  assign out_total_packets        = res_out.pkt_total;
  assign out_total_byte_count     = res_out.byte_total;

`ifndef SYNTHESIS
  a_desc_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> !desc_full)
    else $error("descriptor pushed into a full queue");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_diff_only_compared: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !(out_status == ST_IN_ORDER || out_status == ST_GAP ||
                 out_status == ST_OUT_OF_ORDER)) |-> (out_sequence_diff == '0))
    else $error("nonzero difference on an uncompared result");

  a_none_has_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_NONE) |-> (out_sequence_number == '0))
    else $error("number reported with status none");
`endif

endmodule
